// ===== design/ipv4c_pkg.sv =====
// Shared types, constants and ones'-complement helpers for the IPv4 checksum offload block.
package ipv4c_pkg;

    localparam int MAX_FRAME_BYTES = 2047;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W           = ((POS_W > 16) ? POS_W : 16) + 1;

    localparam int ETH_HDR         = 14;
    localparam int IP_MIN_HDR      = 20;
    localparam int IP_MIN_FRAME    = ETH_HDR + IP_MIN_HDR;
    localparam int POS_ETYPE_HI    = 12;
    localparam int POS_ETYPE_LO    = 13;
    localparam int POS_VER_IHL     = 14;
    localparam int POS_TLEN_HI     = 16;
    localparam int POS_TLEN_LO     = 17;
    localparam int POS_PROTO       = 23;
    localparam int POS_IPCK_HI     = 24;
    localparam int POS_IPCK_LO     = 25;
    localparam int POS_ADDR_FIRST  = 26;
    localparam int POS_ADDR_LAST   = 33;

    localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
    localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [15:0] ICMP_MIN_LEN = 16'd8;
    localparam logic [15:0] TCP_MIN_LEN  = 16'd20;
    localparam logic [15:0] UDP_MIN_LEN  = 16'd8;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_ICMP = 2'd1;
    localparam logic [1:0] KIND_TCP  = 2'd2;
    localparam logic [1:0] KIND_UDP  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } frame_beat_t;

    typedef struct packed {
        logic        ip_fill;
        logic [15:0] ip_checksum;
        logic [1:0]  transport_kind;
        logic [10:0] transport_offset;
        logic [15:0] transport_checksum;
    } result_t;

    // Parser state captured on the final byte of a frame
    typedef struct packed {
        logic             overlong;
        logic [POS_W-1:0] len;
        logic             is_ipv4;
        logic [5:0]       hdr_bytes;
        logic [15:0]      total_len;
        logic [7:0]       proto;
        logic [15:0]      hdr_sum;
        logic [15:0]      tp_sum;
        logic [15:0]      udp_check;
        logic [7:0]       pend;
    } snap_t;

    typedef struct packed {
        logic        ip_ok;
        logic [15:0] ip_checksum;
        logic [1:0]  kind;
        logic [10:0] offset;
        logic [15:0] part_a;
        logic [15:0] part_b;
    } prep_t;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

    function automatic logic [4:0] field_offset(input logic [7:0] proto);
        logic [4:0] off;
        case (proto)
            PROTO_ICMP: off = 5'd2;
            PROTO_TCP:  off = 5'd16;
            PROTO_UDP:  off = 5'd6;
            default:    off = 5'd0;
        endcase
        return off;
    endfunction

endpackage

// ===== design/ipv4c_parse.sv =====
// Input register, per-byte header parser and running sums, frame snapshot register.
module ipv4c_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 frame_valid,
    output logic                 frame_ready,
    input  ipv4c_pkg::frame_beat_t frame,
    output logic                 snap_valid,
    input  logic                 snap_ready,
    output ipv4c_pkg::snap_t     snap
);
    import ipv4c_pkg::*;

    logic             in_v_reg;
    frame_beat_t      in_beat_reg;
    logic             snap_v_reg, snap_v_next;
    snap_t            snap_reg, snap_next;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             is4_reg, is4_next;
    logic [5:0]       hb_reg, hb_next;
    logic [15:0]      tl_reg, tl_next;
    logic [7:0]       pr_reg, pr_next;
    logic [15:0]      hsum_reg, hsum_next;
    logic [15:0]      tsum_reg, tsum_next;
    logic [15:0]      udp_reg, udp_next;
    logic [7:0]       pend_reg, pend_next;
    logic             ovl_reg, ovl_next;

    logic             snap_free, consume, take;
    logic [7:0]       b, v;
    logic             is4_n;
    logic [5:0]       hb_n;
    logic [15:0]      tl_n;
    logic [7:0]       pr_n;
    logic [CMP_W-1:0] pos_x, tstart, tp_end, fpos;
    logic [4:0]       foff;
    logic             active, in_hdr, in_tp, is_fhi, is_flo;
    logic [15:0]      word;

    assign snap_free   = !snap_v_reg || snap_ready;
    assign consume     = in_v_reg && (!in_beat_reg.last_byte || snap_free);
    assign frame_ready = !in_v_reg || consume;
    assign take        = consume && !ovl_reg && (pos_reg < POS_W'(MAX_FRAME_BYTES));
    assign b           = in_beat_reg.data_byte;
    assign pos_x       = CMP_W'(pos_reg);

    always_comb
    begin
        is4_n = is4_reg;
        if (pos_reg == POS_W'(POS_ETYPE_HI))
            is4_n = (b == ETYPE_IPV4_HI);
        else if (pos_reg == POS_W'(POS_ETYPE_LO))
            is4_n = is4_reg && (b == ETYPE_IPV4_LO);

        hb_n = (pos_reg == POS_W'(POS_VER_IHL)) ? {b[3:0], 2'b00} : hb_reg;
        tl_n = tl_reg;
        if (pos_reg == POS_W'(POS_TLEN_HI))
            tl_n = {b, 8'h00};
        else if (pos_reg == POS_W'(POS_TLEN_LO))
            tl_n = {tl_reg[15:8], b};
        pr_n = (pos_reg == POS_W'(POS_PROTO)) ? b : pr_reg;

        active = hb_n >= 6'(IP_MIN_HDR);
        tstart = CMP_W'(ETH_HDR) + CMP_W'(hb_n);
        tp_end = CMP_W'(ETH_HDR) + CMP_W'(tl_n);
        in_hdr = active && (pos_x >= CMP_W'(ETH_HDR)) && (pos_x < tstart);
        in_tp  = active && (pos_x >= tstart) && (pos_x < tp_end);
        foff   = field_offset(pr_n);
        fpos   = tstart + CMP_W'(foff);
        is_fhi = in_tp && (foff != 5'd0) && (pos_x == fpos);
        is_flo = in_tp && (foff != 5'd0) && (pos_x == fpos + CMP_W'(1));

        v = b;
        if (in_hdr && (pos_reg == POS_W'(POS_IPCK_HI) || pos_reg == POS_W'(POS_IPCK_LO)))
            v = 8'h00;
        if (is_fhi || is_flo)
            v = 8'h00;
        word = {pend_reg, v};

        pos_next  = pos_reg;
        is4_next  = is4_reg;
        hb_next   = hb_reg;
        tl_next   = tl_reg;
        pr_next   = pr_reg;
        hsum_next = hsum_reg;
        tsum_next = tsum_reg;
        udp_next  = udp_reg;
        pend_next = pend_reg;
        ovl_next  = ovl_reg;

        if (consume && !ovl_reg && !take)
            ovl_next = 1'b1;

        if (take)
        begin
            pos_next = pos_reg + POS_W'(1);
            is4_next = is4_n;
            hb_next  = hb_n;
            tl_next  = tl_n;
            pr_next  = pr_n;
            if (pr_n == PROTO_UDP && is_fhi)
                udp_next = {b, udp_reg[7:0]};
            else if (pr_n == PROTO_UDP && is_flo)
                udp_next = {udp_reg[15:8], b};
            if (in_hdr || in_tp)
            begin
                if (!pos_reg[0])
                    pend_next = v;
                else if (in_hdr)
                begin
                    hsum_next = oc_add(hsum_reg, word);
                    if (pos_reg >= POS_W'(POS_ADDR_FIRST) && pos_reg <= POS_W'(POS_ADDR_LAST)
                        && (pr_n == PROTO_TCP || pr_n == PROTO_UDP))
                        tsum_next = oc_add(tsum_reg, word);
                end
                else
                    tsum_next = oc_add(tsum_reg, word);
            end
        end

        snap_next.overlong  = ovl_next;
        snap_next.len       = pos_next;
        snap_next.is_ipv4   = is4_next;
        snap_next.hdr_bytes = hb_next;
        snap_next.total_len = tl_next;
        snap_next.proto     = pr_next;
        snap_next.hdr_sum   = hsum_next;
        snap_next.tp_sum    = tsum_next;
        snap_next.udp_check = udp_next;
        snap_next.pend      = pend_next;

        snap_v_next = snap_v_reg && !snap_ready;
        if (consume && in_beat_reg.last_byte)
        begin
            snap_v_next = 1'b1;
            pos_next  = '0;
            is4_next  = 1'b0;
            hb_next   = '0;
            tl_next   = '0;
            pr_next   = '0;
            hsum_next = '0;
            tsum_next = '0;
            udp_next  = '0;
            pend_next = '0;
            ovl_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            snap_v_reg <= 1'b0;
            pos_reg    <= '0;
            is4_reg    <= 1'b0;
            hb_reg     <= '0;
            tl_reg     <= '0;
            pr_reg     <= '0;
            hsum_reg   <= '0;
            tsum_reg   <= '0;
            udp_reg    <= '0;
            pend_reg   <= '0;
            ovl_reg    <= 1'b0;
        end
        else
        begin
            if (frame_ready)
                in_v_reg <= frame_valid;
            snap_v_reg <= snap_v_next;
            pos_reg    <= pos_next;
            is4_reg    <= is4_next;
            hb_reg     <= hb_next;
            tl_reg     <= tl_next;
            pr_reg     <= pr_next;
            hsum_reg   <= hsum_next;
            tsum_reg   <= tsum_next;
            udp_reg    <= udp_next;
            pend_reg   <= pend_next;
            ovl_reg    <= ovl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_ready)
            in_beat_reg <= frame;
        if (consume && in_beat_reg.last_byte)
            snap_reg <= snap_next;
    end

    assign snap_valid = snap_v_reg;
    assign snap       = snap_reg;

endmodule

// ===== design/ipv4c_final.sv =====
// Frame-end checks, pseudo header terms and final checksum fold with output register.
module ipv4c_final (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               snap_valid,
    output logic               snap_ready,
    input  ipv4c_pkg::snap_t   snap,
    output logic               result_valid,
    input  logic               result_ready,
    output ipv4c_pkg::result_t result
);
    import ipv4c_pkg::*;

    logic             prep_v_reg;
    prep_t            prep_reg, prep_next;
    logic             out_v_reg;
    result_t          out_reg, out_next;
    logic             out_load, prep_load;
    logic [CMP_W-1:0] len_x;
    logic [15:0]      plen, tcs;

    assign out_load   = prep_v_reg && (!out_v_reg || result_ready);
    assign snap_ready = !prep_v_reg || out_load;
    assign prep_load  = snap_valid && snap_ready;
    assign len_x      = CMP_W'(snap.len);

    always_comb
    begin
        plen = snap.total_len - {10'b0, snap.hdr_bytes};
        prep_next.ip_ok = !snap.overlong && snap.is_ipv4
            && (len_x >= CMP_W'(IP_MIN_FRAME))
            && (snap.hdr_bytes >= 6'(IP_MIN_HDR))
            && (len_x >= CMP_W'(ETH_HDR) + CMP_W'(snap.total_len))
            && (snap.total_len >= {10'b0, snap.hdr_bytes});

        prep_next.kind = KIND_NONE;
        if (prep_next.ip_ok)
        begin
            if (snap.proto == PROTO_ICMP && plen >= ICMP_MIN_LEN)
                prep_next.kind = KIND_ICMP;
            else if (snap.proto == PROTO_TCP && plen >= TCP_MIN_LEN)
                prep_next.kind = KIND_TCP;
            else if (snap.proto == PROTO_UDP && plen >= UDP_MIN_LEN && snap.udp_check != 16'h0)
                prep_next.kind = KIND_UDP;
        end

        prep_next.ip_checksum = prep_next.ip_ok ? ~snap.hdr_sum : 16'h0000;
        prep_next.offset = (prep_next.kind != KIND_NONE)
            ? 11'(ETH_HDR) + 11'(snap.hdr_bytes) + 11'(field_offset(snap.proto))
            : 11'd0;
        // odd segment: pad the last byte with a zero low byte
        prep_next.part_a = plen[0] ? oc_add(snap.tp_sum, {snap.pend, 8'h00}) : snap.tp_sum;
        prep_next.part_b = (prep_next.kind != KIND_ICMP)
            ? oc_add({8'h00, snap.proto}, plen) : 16'h0000;
    end

    always_comb
    begin
        tcs = ~oc_add(prep_reg.part_a, prep_reg.part_b);
        if (prep_reg.kind == KIND_UDP && tcs == 16'h0000)
            tcs = 16'hFFFF;
        out_next.ip_fill            = prep_reg.ip_ok;
        out_next.ip_checksum        = prep_reg.ip_checksum;
        out_next.transport_kind     = prep_reg.kind;
        out_next.transport_offset   = prep_reg.offset;
        out_next.transport_checksum = (prep_reg.kind != KIND_NONE) ? tcs : 16'h0000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (snap_ready)
                prep_v_reg <= snap_valid;
            if (out_load)
                out_v_reg <= 1'b1;
            else if (result_ready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prep_load)
            prep_reg <= prep_next;
        if (out_load)
            out_reg <= out_next;
    end

    assign result_valid = out_v_reg;
    assign result       = out_reg;

endmodule

// ===== design/ipv4_checksum_offload_top.sv =====
// Top level of the IPv4 header and ICMP/TCP/UDP checksum offload block.
// Throughput: one frame byte per cycle, with no gap between frames, while the result is not stalled.
// The last byte's beat passes in order through the input register, the parser and sums,
//   the frame-end checks, and the checksum fold and output register to the result beat.
// A stalled result backs up through the stages; non-final bytes keep flowing, and only a
//   final byte waits for the snapshot register to be free.
// Reset (rst_n low, asynchronous) clears all valid bits and the parser state.
module ipv4_checksum_offload_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   frame_valid,
    output logic                   frame_ready,
    input  ipv4c_pkg::frame_beat_t frame,
    output logic                   result_valid,
    input  logic                   result_ready,
    output ipv4c_pkg::result_t     result
);
    import ipv4c_pkg::*;

    logic  snap_valid;
    logic  snap_ready;
    snap_t snap;

    ipv4c_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .snap_valid  (snap_valid),
        .snap_ready  (snap_ready),
        .snap        (snap)
    );

    ipv4c_final u_final (
        .clk          (clk),
        .rst_n        (rst_n),
        .snap_valid   (snap_valid),
        .snap_ready   (snap_ready),
        .snap         (snap),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== design/ipv4c_check.sv =====
// Port-level assertions for the checksum offload top level, with bind.
module ipv4c_check (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   result_valid,
    input logic                   result_ready,
    input ipv4c_pkg::result_t     result
);
    import ipv4c_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    a_no_ip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.ip_fill |-> result.ip_checksum == 16'h0000)
        else $error("ip checksum nonzero without fill");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.transport_kind == KIND_NONE
        |-> result.transport_offset == 11'd0 && result.transport_checksum == 16'h0000)
        else $error("transport fields nonzero with no fill");

    a_kind_needs_ip: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.transport_kind != KIND_NONE |-> result.ip_fill)
        else $error("transport fill without ip fill");

    a_udp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.transport_kind == KIND_UDP
        |-> result.transport_checksum != 16'h0000)
        else $error("udp checksum reported as zero");

endmodule

bind ipv4_checksum_offload_top ipv4c_check u_check (.*);
